/* rtl/wcpd_pkg.sv */
package wcpd_pkg;

  // Echo to distance: d = (us * 281) >> 10, in 1/16 cm.
  localparam logic [8:0]  DIST_SCALE      = 9'd281;
  localparam logic [15:0] ECHO_TIMEOUT_US = 16'd10000;
  localparam logic [11:0] DIST_TIMEOUT    = 12'd2400;

  // Serial multiplier: one multiplier bit per cycle.
  localparam int MUL_STEPS = 9;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  localparam logic signed [15:0] ERR_MAX = 16'sd2047;
  localparam logic signed [15:0] ERR_MIN = -16'sd2048;

  // Pivot exit margin in cm.
  localparam logic [8:0] PIVOT_HYST_CM = 9'd10;

  // Register indexes.
  localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [2:0] REG_DERIV_GAIN   = 3'd1;
  localparam logic [2:0] REG_CRUISE_SPEED = 3'd2;
  localparam logic [2:0] REG_FLOOR_SPEED  = 3'd3;
  localparam logic [2:0] REG_CEIL_SPEED   = 3'd4;
  localparam logic [2:0] REG_FRONT_LIMIT  = 3'd5;
  localparam logic [2:0] REG_WALL_LIMIT   = 3'd6;
  localparam logic [2:0] REG_SIDE_TARGET  = 3'd7;

  localparam logic [7:0] RST_PROP_GAIN    = 8'd104;
  localparam logic [7:0] RST_DERIV_GAIN   = 8'd51;
  localparam logic [7:0] RST_CRUISE_SPEED = 8'd220;
  localparam logic [7:0] RST_FLOOR_SPEED  = 8'd100;
  localparam logic [7:0] RST_CEIL_SPEED   = 8'd255;
  localparam logic [7:0] RST_FRONT_LIMIT  = 8'd25;
  localparam logic [7:0] RST_WALL_LIMIT   = 8'd60;
  localparam logic [7:0] RST_SIDE_TARGET  = 8'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRONT,
    ST_LEFT,
    ST_RIGHT,
    ST_DECIDE,
    ST_ERROR,
    ST_PROP,
    ST_DERIV,
    ST_WHEEL,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic               start;
    logic signed [14:0] mcand;
    logic [8:0]         mplier;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [23:0] product;
  } mul_rsp_t;

endpackage

/* rtl/wcpd_echo_if.sv */
interface wcpd_echo_if;
  logic        valid;
  logic        ready;
  logic [13:0] front_echo_us;
  logic [13:0] left_echo_us;
  logic [13:0] right_echo_us;

  modport source (
    output valid, front_echo_us, left_echo_us, right_echo_us,
    input  ready
  );
  modport sink (
    input  valid, front_echo_us, left_echo_us, right_echo_us,
    output ready
  );
endinterface

/* rtl/wcpd_drive_if.sv */
interface wcpd_drive_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic       left_forward;
  logic       right_forward;
  logic       in_pivot;

  modport source (
    output valid, left_speed, right_speed, left_forward, right_forward, in_pivot,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, left_forward, right_forward, in_pivot,
    output ready
  );
endinterface

/* rtl/wcpd_serial_mul.sv */
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one
// multiplier bit per cycle. done rises together with the last step's sum in acc.
module wcpd_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  wcpd_pkg::mul_req_t req,
  output wcpd_pkg::mul_rsp_t rsp
);

  logic signed [23:0] mc;
  logic [8:0]         mp;
  logic signed [23:0] acc;
  logic [wcpd_pkg::MUL_CNT_W-1:0] cnt;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= wcpd_pkg::MUL_CNT_W'(wcpd_pkg::MUL_STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == wcpd_pkg::MUL_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mc  <= {{9{req.mcand[14]}}, req.mcand};
      mp  <= req.mplier;
      acc <= '0;
    end else if (cnt != '0) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc <<< 1;
      mp <= mp >> 1;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

/* rtl/wall_centering_pd_steering.sv */
// Channel  Modport               Carries
// echo     wcpd_echo_if.sink     front/left/right echo times, us, 14 bits each
// drive    wcpd_drive_if.source  left/right PWM, direction bits, pivot flag
// apb      psel..pready          eight 8-bit registers at byte address 4*i
//
// One request at a time; each product takes a pass through one shared
// 9-step bit-serial multiplier: three echo scalings, plus P and D when steering.
// Reset (rst, synchronous) restores register defaults and clears the error
// history and pivot state. A result still held in the output register stalls
// only the final load, until drive.ready.
module wall_centering_pd_steering (
  input  logic                clk,
  input  logic                rst,
  wcpd_echo_if.sink           echo,
  wcpd_drive_if.source        drive,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0] prop_gain, deriv_gain, cruise_speed, floor_speed;
  logic [7:0] ceiling_speed, front_limit_cm, wall_limit_cm, side_target_cm;

  wcpd_pkg::state_t state, state_next;
  wcpd_pkg::mul_req_t mul_req;
  wcpd_pkg::mul_rsp_t mul_rsp;

  logic [13:0] front_us, left_us, right_us;
  logic [11:0] f_dist, l_dist, r_dist;
  logic signed [11:0] prev_err, err;
  logic signed [12:0] diff;
  logic               diff_scale;
  logic               pivot_active, pivot_to_left, do_pivot;
  logic signed [23:0] psum;
  logic signed [16:0] left_v, right_v;

  logic signed [11:0] err_next;
  logic signed [12:0] err_delta;
  logic               load_ok;

  logic       out_valid;
  logic [7:0] out_left_speed, out_right_speed;
  logic       out_left_fwd, out_right_fwd, out_pivot;

  wcpd_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  function automatic logic [11:0] echo_dist(input logic [13:0] us,
                                            input logic [23:0] prod);
    if (us == 14'd0 || {2'b00, us} > wcpd_pkg::ECHO_TIMEOUT_US) begin
      return wcpd_pkg::DIST_TIMEOUT;
    end
    return prod[21:10];
  endfunction

  function automatic logic [7:0] clamp_pwm(input logic signed [16:0] v,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    if (v < $signed({9'b0, lo})) begin
      return lo;
    end
    if (v > $signed({9'b0, hi})) begin
      return hi;
    end
    return v[7:0];
  endfunction

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= wcpd_pkg::RST_PROP_GAIN;
      deriv_gain     <= wcpd_pkg::RST_DERIV_GAIN;
      cruise_speed   <= wcpd_pkg::RST_CRUISE_SPEED;
      floor_speed    <= wcpd_pkg::RST_FLOOR_SPEED;
      ceiling_speed  <= wcpd_pkg::RST_CEIL_SPEED;
      front_limit_cm <= wcpd_pkg::RST_FRONT_LIMIT;
      wall_limit_cm  <= wcpd_pkg::RST_WALL_LIMIT;
      side_target_cm <= wcpd_pkg::RST_SIDE_TARGET;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        wcpd_pkg::REG_PROP_GAIN:    prop_gain      <= pwdata[7:0];
        wcpd_pkg::REG_DERIV_GAIN:   deriv_gain     <= pwdata[7:0];
        wcpd_pkg::REG_CRUISE_SPEED: cruise_speed   <= pwdata[7:0];
        wcpd_pkg::REG_FLOOR_SPEED:  floor_speed    <= pwdata[7:0];
        wcpd_pkg::REG_CEIL_SPEED:   ceiling_speed  <= pwdata[7:0];
        wcpd_pkg::REG_FRONT_LIMIT:  front_limit_cm <= pwdata[7:0];
        wcpd_pkg::REG_WALL_LIMIT:   wall_limit_cm  <= pwdata[7:0];
        wcpd_pkg::REG_SIDE_TARGET:  side_target_cm <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      wcpd_pkg::REG_PROP_GAIN:    prdata = {24'b0, prop_gain};
      wcpd_pkg::REG_DERIV_GAIN:   prdata = {24'b0, deriv_gain};
      wcpd_pkg::REG_CRUISE_SPEED: prdata = {24'b0, cruise_speed};
      wcpd_pkg::REG_FLOOR_SPEED:  prdata = {24'b0, floor_speed};
      wcpd_pkg::REG_CEIL_SPEED:   prdata = {24'b0, ceiling_speed};
      wcpd_pkg::REG_FRONT_LIMIT:  prdata = {24'b0, front_limit_cm};
      wcpd_pkg::REG_WALL_LIMIT:   prdata = {24'b0, wall_limit_cm};
      wcpd_pkg::REG_SIDE_TARGET:  prdata = {24'b0, side_target_cm};
      default:                    prdata = 32'b0;
    endcase
  end

  // Error: plain wall difference, or 1.5x offset from target, saturated.
  always_comb begin
    logic signed [15:0] d16;
    logic signed [15:0] s;
    d16 = {{3{diff[12]}}, diff};
    s   = diff_scale ? ((d16 + (d16 <<< 1)) >>> 1) : d16;
    if (s > wcpd_pkg::ERR_MAX) begin
      err_next = wcpd_pkg::ERR_MAX[11:0];
    end else if (s < wcpd_pkg::ERR_MIN) begin
      err_next = wcpd_pkg::ERR_MIN[11:0];
    end else begin
      err_next = s[11:0];
    end
  end

  assign err_delta = {err[11], err} - {prev_err[11], prev_err};
  assign load_ok   = !out_valid || drive.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wcpd_pkg::ST_IDLE:   if (echo.valid) state_next = wcpd_pkg::ST_FRONT;
      wcpd_pkg::ST_FRONT:  if (mul_rsp.done) state_next = wcpd_pkg::ST_LEFT;
      wcpd_pkg::ST_LEFT:   if (mul_rsp.done) state_next = wcpd_pkg::ST_RIGHT;
      wcpd_pkg::ST_RIGHT:  if (mul_rsp.done) state_next = wcpd_pkg::ST_DECIDE;
      wcpd_pkg::ST_DECIDE: begin
        if (pivot_active ||
            (f_dist != 12'd0 && f_dist < {front_limit_cm, 4'b0000})) begin
          state_next = wcpd_pkg::ST_LOAD;
        end else begin
          state_next = wcpd_pkg::ST_ERROR;
        end
      end
      wcpd_pkg::ST_ERROR:  state_next = wcpd_pkg::ST_PROP;
      wcpd_pkg::ST_PROP:   if (mul_rsp.done) state_next = wcpd_pkg::ST_DERIV;
      wcpd_pkg::ST_DERIV:  if (mul_rsp.done) state_next = wcpd_pkg::ST_WHEEL;
      wcpd_pkg::ST_WHEEL:  state_next = wcpd_pkg::ST_LOAD;
      wcpd_pkg::ST_LOAD:   if (load_ok) state_next = wcpd_pkg::ST_IDLE;
      default:             state_next = wcpd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier requests
  always_comb begin
    echo.ready     = 1'b0;
    mul_req.start  = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    case (state)
      wcpd_pkg::ST_IDLE: begin
        echo.ready     = 1'b1;
        mul_req.start  = echo.valid;
        mul_req.mcand  = {1'b0, echo.front_echo_us};
        mul_req.mplier = wcpd_pkg::DIST_SCALE;
      end
      wcpd_pkg::ST_FRONT: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = {1'b0, left_us};
        mul_req.mplier = wcpd_pkg::DIST_SCALE;
      end
      wcpd_pkg::ST_LEFT: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = {1'b0, right_us};
        mul_req.mplier = wcpd_pkg::DIST_SCALE;
      end
      wcpd_pkg::ST_ERROR: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{3{err_next[11]}}, err_next};
        mul_req.mplier = {1'b0, prop_gain};
      end
      wcpd_pkg::ST_PROP: begin
        mul_req.start  = mul_rsp.done;
        mul_req.mcand  = {{2{err_delta[12]}}, err_delta};
        mul_req.mplier = {1'b0, deriv_gain};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err      <= '0;
      pivot_active  <= 1'b0;
      pivot_to_left <= 1'b0;
    end else begin
      if (state == wcpd_pkg::ST_DECIDE) begin
        if (pivot_active) begin
          if ({1'b0, f_dist} >= {({1'b0, front_limit_cm} + wcpd_pkg::PIVOT_HYST_CM), 4'b0000}
              ) begin
            pivot_active <= 1'b0;
          end
        end else if (f_dist != 12'd0 && f_dist < {front_limit_cm, 4'b0000}) begin
          pivot_active  <= 1'b1;
          pivot_to_left <= l_dist > r_dist;
        end
      end
      if (state == wcpd_pkg::ST_PROP && mul_rsp.done) begin
        prev_err <= err;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic [11:0] wall_lim;
    logic [11:0] tgt;
    logic        lw, rw;
    logic signed [15:0] q;
    logic signed [16:0] a, b;
    logic        rnz;
    wall_lim = {wall_limit_cm, 4'b0000};
    tgt      = {side_target_cm, 4'b0000};
    lw       = l_dist != 12'd0 && l_dist < wall_lim;
    rw       = r_dist != 12'd0 && r_dist < wall_lim;
    q        = psum[23:8];
    rnz      = psum[7:0] != 8'd0;
    a        = $signed({9'b0, cruise_speed}) - {q[15], q};
    b        = $signed({9'b0, cruise_speed}) + {q[15], q};

    if (state == wcpd_pkg::ST_IDLE && echo.valid) begin
      front_us <= echo.front_echo_us;
      left_us  <= echo.left_echo_us;
      right_us <= echo.right_echo_us;
    end
    if (state == wcpd_pkg::ST_FRONT && mul_rsp.done) begin
      f_dist <= echo_dist(front_us, mul_rsp.product);
    end
    if (state == wcpd_pkg::ST_LEFT && mul_rsp.done) begin
      l_dist <= echo_dist(left_us, mul_rsp.product);
    end
    if (state == wcpd_pkg::ST_RIGHT && mul_rsp.done) begin
      r_dist <= echo_dist(right_us, mul_rsp.product);
    end
    if (state == wcpd_pkg::ST_DECIDE) begin
      do_pivot   <= state_next == wcpd_pkg::ST_LOAD;
      diff_scale <= !(lw && rw) && (lw || rw);
      if (lw && rw) begin
        diff <= {1'b0, l_dist} - {1'b0, r_dist};
      end else if (lw) begin
        diff <= {1'b0, l_dist} - {1'b0, tgt};
      end else if (rw) begin
        diff <= {1'b0, tgt} - {1'b0, r_dist};
      end else begin
        diff <= '0;
      end
    end
    if (state == wcpd_pkg::ST_ERROR) begin
      err <= err_next;
    end
    if (state == wcpd_pkg::ST_PROP && mul_rsp.done) begin
      psum <= mul_rsp.product;
    end
    if (state == wcpd_pkg::ST_DERIV && mul_rsp.done) begin
      psum <= psum + mul_rsp.product;
    end
    // Truncate toward zero: a nonzero fraction moves the quotient toward 0.
    if (state == wcpd_pkg::ST_WHEEL) begin
      left_v  <= (rnz && a > 17'sd0) ? a - 17'sd1 : a;
      right_v <= (rnz && b < 17'sd0) ? b + 17'sd1 : b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == wcpd_pkg::ST_LOAD && load_ok) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wcpd_pkg::ST_LOAD && load_ok) begin
      if (do_pivot) begin
        out_left_speed  <= ceiling_speed;
        out_right_speed <= ceiling_speed;
        out_left_fwd    <= !pivot_to_left;
        out_right_fwd   <= pivot_to_left;
        out_pivot       <= pivot_active;
      end else begin
        out_left_speed  <= clamp_pwm(left_v, floor_speed, ceiling_speed);
        out_right_speed <= clamp_pwm(right_v, floor_speed, ceiling_speed);
        out_left_fwd    <= 1'b1;
        out_right_fwd   <= 1'b1;
        out_pivot       <= 1'b0;
      end
    end
  end

  assign drive.valid         = out_valid;
  assign drive.left_speed    = out_left_speed;
  assign drive.right_speed   = out_right_speed;
  assign drive.left_forward  = out_left_fwd;
  assign drive.right_forward = out_right_fwd;
  assign drive.in_pivot      = out_pivot;

endmodule

/* bench/wall_centering_pd_steering_tb.sv */
`timescale 1ns / 100ps

module wall_centering_pd_steering_tb;

  typedef struct packed {
    logic [13:0] front;
    logic [13:0] left;
    logic [13:0] right;
  } echo_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       left_forward;
    logic       right_forward;
    logic       in_pivot;
  } drive_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wcpd_echo_if  echo_bus ();
  wcpd_drive_if drive_bus ();

  wall_centering_pd_steering i_dut (
    .clk     (clk),
    .rst     (rst),
    .echo    (echo_bus),
    .drive   (drive_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Steering state as the block should hold it
  logic [7:0]         cfg [8];
  logic signed [11:0] prev_err;
  logic               pivot_on;
  logic               pivot_left;

  echo_t  echo_queue[$];
  drive_t drive_expect[$];
  echo_t  next_req;
  drive_t want;
  int     drive_errs;
  int     send_idle;
  int     recv_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("wall_centering_pd_steering_tb: errors");
    $finish;
  end

  function automatic int echo_dist(logic [13:0] us);
    if (us == 0 || us > wcpd_pkg::ECHO_TIMEOUT_US) return int'(wcpd_pkg::DIST_TIMEOUT);
    return (int'(us) * int'(wcpd_pkg::DIST_SCALE)) >>> 10;
  endfunction

  // floor wins over ceiling when they cross
  function automatic logic [7:0] clamp_duty(int v);
    if (v < int'(cfg[wcpd_pkg::REG_FLOOR_SPEED])) return cfg[wcpd_pkg::REG_FLOOR_SPEED];
    if (v > int'(cfg[wcpd_pkg::REG_CEIL_SPEED])) return cfg[wcpd_pkg::REG_CEIL_SPEED];
    return v[7:0];
  endfunction

  function automatic drive_t steer_predict(echo_t req);
    int f, l, r, wall, tgt, front, base, e, p;
    logic lw, rw;
    drive_t d;
    f = echo_dist(req.front);
    l = echo_dist(req.left);
    r = echo_dist(req.right);
    wall  = int'(cfg[wcpd_pkg::REG_WALL_LIMIT]) * 16;
    tgt   = int'(cfg[wcpd_pkg::REG_SIDE_TARGET]) * 16;
    front = int'(cfg[wcpd_pkg::REG_FRONT_LIMIT]);
    base  = int'(cfg[wcpd_pkg::REG_CRUISE_SPEED]) * 256;
    if (pivot_on || (f > 0 && f < front * 16)) begin
      if (!pivot_on) begin
        pivot_on   = 1'b1;
        pivot_left = l > r;
      end else if (f >= (front + int'(wcpd_pkg::PIVOT_HYST_CM)) * 16) begin
        // last pivot drive goes out with the flag already down
        pivot_on = 1'b0;
      end
      d.left_speed    = cfg[wcpd_pkg::REG_CEIL_SPEED];
      d.right_speed   = cfg[wcpd_pkg::REG_CEIL_SPEED];
      d.left_forward  = !pivot_left;
      d.right_forward = pivot_left;
      d.in_pivot      = pivot_on;
      return d;
    end
    lw = l > 0 && l < wall;
    rw = r > 0 && r < wall;
    if (lw && rw) e = l - r;
    else if (lw) e = (3 * (l - tgt)) >>> 1;
    else if (rw) e = (3 * (tgt - r)) >>> 1;
    else e = 0;
    if (e > int'(wcpd_pkg::ERR_MAX)) e = int'(wcpd_pkg::ERR_MAX);
    if (e < int'(wcpd_pkg::ERR_MIN)) e = int'(wcpd_pkg::ERR_MIN);
    p = int'(cfg[wcpd_pkg::REG_PROP_GAIN]) * e
        + int'(cfg[wcpd_pkg::REG_DERIV_GAIN]) * (e - int'(prev_err));
    prev_err = e[11:0];
    d.left_speed    = clamp_duty((base - p) / 256);
    d.right_speed   = clamp_duty((base + p) / 256);
    d.left_forward  = 1'b1;
    d.right_forward = 1'b1;
    d.in_pivot      = 1'b0;
    return d;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      drive_errs++;
    end
  endtask

  // Echo request driver
  always @(posedge clk) begin
    if (rst) begin
      echo_bus.valid <= 1'b0;
    end else begin
      if (echo_bus.valid && echo_bus.ready)
        drive_expect.push_back(steer_predict(echo_t'{echo_bus.front_echo_us,
                                                     echo_bus.left_echo_us,
                                                     echo_bus.right_echo_us}));
      if (!echo_bus.valid || echo_bus.ready) begin
        if (echo_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_req = echo_queue.pop_front();
          echo_bus.valid         <= 1'b1;
          echo_bus.front_echo_us <= next_req.front;
          echo_bus.left_echo_us  <= next_req.left;
          echo_bus.right_echo_us <= next_req.right;
        end else begin
          echo_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Drive request monitor
  always @(posedge clk) begin
    if (rst) begin
      drive_bus.ready <= 1'b0;
    end else begin
      if (drive_bus.valid && drive_bus.ready) begin
        if (drive_expect.size() == 0) begin
          $error("drive request with nothing expected");
          drive_errs++;
        end else begin
          want = drive_expect.pop_front();
          check_field("left_speed", want.left_speed, drive_bus.left_speed);
          check_field("right_speed", want.right_speed, drive_bus.right_speed);
          check_field("left_forward", 8'(want.left_forward), 8'(drive_bus.left_forward));
          check_field("right_forward", 8'(want.right_forward),
                      8'(drive_bus.right_forward));
          check_field("in_pivot", 8'(want.in_pivot), 8'(drive_bus.in_pivot));
        end
      end
      drive_bus.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(logic [7:0] pg, logic [7:0] dg, logic [7:0] cs, logic [7:0] fs,
                             logic [7:0] cl, logic [7:0] fl, logic [7:0] wl, logic [7:0] st);
    write_reg(wcpd_pkg::REG_PROP_GAIN, pg);
    write_reg(wcpd_pkg::REG_DERIV_GAIN, dg);
    write_reg(wcpd_pkg::REG_CRUISE_SPEED, cs);
    write_reg(wcpd_pkg::REG_FLOOR_SPEED, fs);
    write_reg(wcpd_pkg::REG_CEIL_SPEED, cl);
    write_reg(wcpd_pkg::REG_FRONT_LIMIT, fl);
    write_reg(wcpd_pkg::REG_WALL_LIMIT, wl);
    write_reg(wcpd_pkg::REG_SIDE_TARGET, st);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (echo_queue.size() != 0 || echo_bus.valid || drive_expect.size() != 0);
  endtask

  task automatic push_echo(int f, int l, int r);
    echo_queue.push_back(echo_t'{f[13:0], l[13:0], r[13:0]});
  endtask

  // near-wall or near-limit times and times anywhere in equal share, some timeouts
  function automatic int rand_echo(int span);
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(16383, 10001);
      2, 3, 4, 5: return $urandom_range(span);
      default: return $urandom_range(10000, 1);
    endcase
  endfunction

  initial begin
    int n, fl, wl, stays;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    echo_bus.valid = 1'b0;
    echo_bus.front_echo_us = '0;
    echo_bus.left_echo_us = '0;
    echo_bus.right_echo_us = '0;
    drive_bus.ready = 1'b0;
    cfg[wcpd_pkg::REG_PROP_GAIN]    = wcpd_pkg::RST_PROP_GAIN;
    cfg[wcpd_pkg::REG_DERIV_GAIN]   = wcpd_pkg::RST_DERIV_GAIN;
    cfg[wcpd_pkg::REG_CRUISE_SPEED] = wcpd_pkg::RST_CRUISE_SPEED;
    cfg[wcpd_pkg::REG_FLOOR_SPEED]  = wcpd_pkg::RST_FLOOR_SPEED;
    cfg[wcpd_pkg::REG_CEIL_SPEED]   = wcpd_pkg::RST_CEIL_SPEED;
    cfg[wcpd_pkg::REG_FRONT_LIMIT]  = wcpd_pkg::RST_FRONT_LIMIT;
    cfg[wcpd_pkg::REG_WALL_LIMIT]   = wcpd_pkg::RST_WALL_LIMIT;
    cfg[wcpd_pkg::REG_SIDE_TARGET]  = wcpd_pkg::RST_SIDE_TARGET;
    prev_err = '0;
    pivot_on = 1'b0;
    pivot_left = 1'b0;
    drive_errs = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset config: pivot entry at 1457us, exit at 2041us, walls at 3498us
    push_echo(0, 0, 0);
    push_echo(16383, 16383, 16383);
    push_echo(10000, 10000, 10000);
    push_echo(10001, 1, 1);           // zero-distance sides don't count
    push_echo(3000, 1000, 2000);
    push_echo(3000, 1500, 0);
    push_echo(3000, 0, 1500);
    push_echo(1, 500, 9000);          // front rounds to zero: no pivot
    push_echo(1457, 3000, 1000);      // spin left
    push_echo(1000, 0, 0);
    push_echo(2040, 0, 0);
    push_echo(2041, 0, 0);            // pivot ends
    push_echo(1458, 2000, 2000);
    push_echo(800, 2000, 2000);       // tie spins right
    push_echo(16383, 0, 0);
    push_echo(3500, 3400, 100);
    push_echo(3000, 3498, 3499);
    push_echo(3000, 3499, 3498);
    push_echo(5000, 100, 3498);
    push_echo(5000, 9999, 8191);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: ;
        1: load_config(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd150, 8'd150, 8'd150);
        2: load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        3: load_config(wcpd_pkg::RST_PROP_GAIN, wcpd_pkg::RST_DERIV_GAIN,
                       wcpd_pkg::RST_CRUISE_SPEED, 8'd200, 8'd50,
                       wcpd_pkg::RST_FRONT_LIMIT, wcpd_pkg::RST_WALL_LIMIT,
                       wcpd_pkg::RST_SIDE_TARGET);
        default: load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(150)),
                             8'($urandom_range(150)), 8'($urandom_range(150)));
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      fl = int'(cfg[wcpd_pkg::REG_FRONT_LIMIT]);
      wl = int'(cfg[wcpd_pkg::REG_WALL_LIMIT]);
      n = 0;
      while (n < 64) begin
        if ($urandom_range(5) == 0) begin
          // obstacle ahead, lingers a few requests, then clears
          push_echo($urandom_range(fl * 58 + 8, 1), rand_echo(wl * 59 + 100),
                    rand_echo(wl * 59 + 100));
          stays = $urandom_range(3);
          for (int k = 0; k < stays; k++)
            push_echo($urandom_range((fl + 10) * 58 + 20, 1), rand_echo(10000),
                      rand_echo(10000));
          push_echo($urandom_range(10000, (fl + 10) * 60), rand_echo(10000), rand_echo(10000));
          n += stays + 2;
        end else begin
          push_echo(rand_echo(fl * 59 + 800), rand_echo(wl * 59 + 100),
                    rand_echo(wl * 59 + 100));
          n++;
        end
      end
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (drive_errs == 0)
      $display("wall_centering_pd_steering_tb: clean");
    else
      $display("wall_centering_pd_steering_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wcpd_pkg.sv
rtl/wcpd_echo_if.sv
rtl/wcpd_drive_if.sv
rtl/wcpd_serial_mul.sv
rtl/wall_centering_pd_steering.sv
bench/wall_centering_pd_steering_tb.sv
